### src/fdc_pkg.sv
`default_nettype none

package fdc_pkg;

  // Header layout.
  localparam int unsigned HDR_LEN  = 10;
  localparam int unsigned POS_W    = 33;
  localparam int unsigned TYPE_MAX = 9;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Magic "CYP2" at offsets 0..3.
  localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h59, 8'h50, 8'h32};

  // Header offsets with a check of their own.
  localparam logic [3:0] OFS_VERSION = 4'd4;
  localparam logic [3:0] OFS_TYPE    = 4'd5;
  localparam logic [3:0] OFS_LEN0    = 4'd6;
  localparam logic [3:0] OFS_LEN3    = 4'd9;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_TYPE     = 3'd4,
    ST_TOO_LONG = 3'd5,
    ST_MISMATCH = 3'd6
  } status_t;

  typedef enum logic {
    CFG_VERSION         = 1'b0,
    CFG_MAX_PAYLOAD_LEN = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

### src/frame_deframer_checker.sv
`default_nettype none

// Streaming checker for a framed receive buffer, one byte per transaction.
// Input channel: in_byte with in_last on the buffer's final byte, under
// in_valid/in_ready. Result channel: exactly one result per input byte under
// out_valid/out_ready: payload echo (out_byte, out_is_payload), the frame type
// seen so far, the declared length (zero until the header is complete), and
// on the final byte out_done with out_status (0 ok, 1 short, 2 magic,
// 3 version, 4 type, 5 too long, 6 length mismatch).
// The result of a byte is in the output register in the cycle after its
// acceptance. Throughput is one byte per cycle while the receiver keeps up,
// set by the single output register; in_ready stays high while that register
// is empty or being taken in the same cycle.
// When the receiver stalls, the result is held and in_ready falls until it is
// taken; no result is lost.
// Reset (rst_n low, synchronous) empties the output register, clears the frame
// state and loads the expected version 1 and the maximum payload length 65536.
// cfg_we writes register cfg_index (0 expected version, 1 max payload length)
// at once; configure only while no frame is in progress.
module frame_deframer_checker
  import fdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_is_payload,
  output logic [3:0]       out_type,
  output logic [31:0]      out_length,
  output logic             out_done,
  output logic [2:0]       out_status
);

  logic [7:0]       version_r;
  logic [31:0]      max_len_r;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  status_t          err_r, err_nxt;
  logic [3:0]       type_r, type_nxt;
  logic [31:0]      len_r, len_nxt;

  logic             out_valid_r;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_is_payload_r, out_is_payload_nxt;
  logic [3:0]       out_type_r;
  logic [31:0]      out_length_r, out_length_nxt;
  logic             out_done_r;
  status_t          out_status_r, status_nxt;

  logic             in_fire;
  logic [1:0]       len_lane;
  logic             in_hdr;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd1;
      max_len_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VERSION:         version_r <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_hdr   = pos_r < POS_W'(HDR_LEN);
  assign len_lane = 2'(pos_r[3:0] - OFS_LEN0);

  always_comb begin
    err_nxt            = err_r;
    type_nxt           = type_r;
    len_nxt            = len_r;
    out_is_payload_nxt = 1'b0;

    if (!in_hdr) begin
      out_is_payload_nxt = 1'b1;
    end else if (pos_r[3:0] < OFS_VERSION) begin
      if (in_byte != MAGIC[pos_r[1:0]] && err_r == ST_OK) err_nxt = ST_MAGIC;
    end else if (pos_r[3:0] == OFS_VERSION) begin
      if (in_byte != version_r && err_r == ST_OK) err_nxt = ST_VERSION;
    end else if (pos_r[3:0] == OFS_TYPE) begin
      if (in_byte >= 8'd1 && in_byte <= 8'(TYPE_MAX)) begin
        type_nxt = in_byte[3:0];
      end else if (err_r == ST_OK) begin
        err_nxt = ST_TYPE;
      end
    end else begin
      len_nxt = len_r | ({24'd0, in_byte} << {len_lane, 3'b000});
      if (pos_r[3:0] == OFS_LEN3 && len_nxt > max_len_r && err_r == ST_OK) begin
        err_nxt = ST_TOO_LONG;
      end
    end

    pos_inc = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;

    out_byte_nxt   = out_is_payload_nxt ? in_byte : 8'd0;
    out_length_nxt = (pos_inc >= POS_W'(HDR_LEN)) ? len_nxt : 32'd0;

    status_nxt = ST_OK;
    if (in_last) begin
      if (pos_inc < POS_W'(HDR_LEN)) begin
        status_nxt = ST_SHORT;
      end else if (err_nxt != ST_OK) begin
        status_nxt = err_nxt;
      end else if (pos_inc != POS_W'(HDR_LEN) + {1'b0, len_nxt}) begin
        status_nxt = ST_MISMATCH;
      end
    end

    pos_nxt = in_last ? '0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      err_r  <= ST_OK;
      type_r <= 4'd0;
      len_r  <= 32'd0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      err_r  <= in_last ? ST_OK : err_nxt;
      type_r <= in_last ? 4'd0  : type_nxt;
      len_r  <= in_last ? 32'd0 : len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r       <= out_byte_nxt;
      out_is_payload_r <= out_is_payload_nxt;
      out_type_r       <= type_nxt;
      out_length_r     <= out_length_nxt;
      out_done_r       <= in_last;
      out_status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_payload = out_is_payload_r;
  assign out_type       = out_type_r;
  assign out_length     = out_length_r;
  assign out_done       = out_done_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

### src/fdc_checker.sv
`default_nettype none

module fdc_checker
  import fdc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        out_is_payload,
  input wire logic        out_done,
  input wire logic [2:0]  out_status
);

  // A stalled result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status)
                                && $stable(out_done))
    else $error("result changed while stalled");

  // The input side only stalls behind a held result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // Status is only reported on the final byte, and header bytes echo nothing.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done |-> out_status == ST_OK && (out_is_payload || out_byte == 8'd0))
    else $error("status or echo outside its place");

  // A buffer that reached the payload is never short.
  a_no_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done && out_is_payload |-> out_status != ST_SHORT)
    else $error("short status after full header");

endmodule

bind frame_deframer_checker fdc_checker u_fdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_is_payload (out_is_payload),
  .out_done       (out_done),
  .out_status     (out_status)
);

`default_nettype wire
